// ===== sv/chte_pkg.sv =====
// package: types and constants shared by the hash table engine
package chte_pkg;

  localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;

  localparam logic [2:0] FUNC_PUT      = 3'd0;
  localparam logic [2:0] FUNC_GET      = 3'd1;
  localparam logic [2:0] FUNC_POP      = 3'd2;
  localparam logic [2:0] FUNC_CONTAINS = 3'd3;
  localparam logic [2:0] FUNC_CLEAR    = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef enum logic [1:0] {
    HS_IDLE,
    HS_MUL,
    HS_DONE
  } hash_state_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_WAIT,
    ST_HASH,
    ST_HEAD,
    ST_READ,
    ST_CMP,
    ST_ACT,
    ST_FREE,
    ST_WR,
    ST_CLR,
    ST_RESP
  } eng_state_t;

endpackage

// ===== sv/chte_hash.sv =====
// murmur 64-bit finalizer, multiplies done as 32x32 partial products over cycles
module chte_hash (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] key,
  output logic        done,
  output logic [63:0] hash
);

  chte_pkg::hash_state_t state, state_next;
  logic [63:0] x;
  logic [63:0] acc;
  logic [1:0]  part;
  logic        round;
  logic [63:0] mult;
  logic [31:0] a_half;
  logic [31:0] b_half;
  logic [63:0] prod;
  logic [63:0] term;

  assign mult   = round ? chte_pkg::MIX_C2 : chte_pkg::MIX_C1;
  assign a_half = part[1] ? x[63:32] : x[31:0];
  assign b_half = part[0] ? mult[63:32] : mult[31:0];
  assign prod   = {32'd0, a_half} * {32'd0, b_half};

  always_comb begin
    unique case (part)
      2'd0: term = prod;
      2'd1: term = {prod[31:0], 32'd0};
      2'd2: term = {prod[31:0], 32'd0};
      default: term = 64'd0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      chte_pkg::HS_IDLE: if (start) state_next = chte_pkg::HS_MUL;
      chte_pkg::HS_MUL: if (part == 2'd3 && round) state_next = chte_pkg::HS_DONE;
      chte_pkg::HS_DONE: state_next = chte_pkg::HS_IDLE;
      default: state_next = chte_pkg::HS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= chte_pkg::HS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      chte_pkg::HS_IDLE: begin
        // first xor-shift leaves a 32-bit key unchanged
        x     <= {32'd0, key};
        acc   <= 64'd0;
        part  <= 2'd0;
        round <= 1'b0;
      end
      chte_pkg::HS_MUL: begin
        if (part == 2'd3) begin
          x     <= acc ^ (acc >> 33);
          acc   <= 64'd0;
          part  <= 2'd0;
          round <= 1'b1;
        end else begin
          acc  <= acc + term;
          part <= part + 2'd1;
        end
      end
      default: ;
    endcase
  end

  assign done = (state == chte_pkg::HS_DONE);
  assign hash = x;

endmodule

// ===== sv/chained_hash_table_engine.sv =====
// top level: chained hash table engine with node pool and free stack
// a get, put, pop or contains hashes the key, then walks its bucket chain one node at a time;
// a put of a new key also takes a free node; clear sweeps the tables; an unknown op goes straight to the response
// throughput: one word at a time; busy stays high from accept until the result strobe
// reset: synchronous, active high; a sweep fills the free stack before busy drops
// results cannot be stalled by the receiver
module chained_hash_table_engine #(
  parameter int NUM_BUCKETS = 16,
  parameter int POOL_NODES  = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  func,
  input  logic [31:0] key,
  input  logic [31:0] value,
  output logic        strobe,
  output logic [1:0]  status,
  output logic        found,
  output logic [31:0] value_out,
  output logic [6:0]  entry_count
);

  localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int NW = $clog2(POOL_NODES);
  localparam int LW = $clog2(POOL_NODES + 1);
  localparam int SWEEP_N = (POOL_NODES > NUM_BUCKETS) ? POOL_NODES : NUM_BUCKETS;
  localparam int SW = $clog2(SWEEP_N + 1);
  localparam logic [LW-1:0] NULL_LINK = LW'(POOL_NODES);

  logic [LW-1:0] bucket_head [NUM_BUCKETS];
  logic [31:0]   node_key    [POOL_NODES];
  logic [31:0]   node_value  [POOL_NODES];
  logic [LW-1:0] node_next   [POOL_NODES];
  logic [NW-1:0] free_stack  [POOL_NODES];

  chte_pkg::eng_state_t state, state_next;
  logic [LW-1:0] free_top;
  logic [LW-1:0] stored_count;
  logic [SW-1:0] sweep;
  logic          sweep_last;
  logic [2:0]    op;
  logic [31:0]   op_key;
  logic [31:0]   op_value;
  logic [BW-1:0] bucket;
  logic [LW-1:0] cur;
  logic [LW-1:0] prev;
  logic [LW:0]   steps;
  logic [31:0]   rd_key;
  logic [31:0]   rd_value;
  logic [LW-1:0] rd_next;
  logic [NW-1:0] rd_free;
  logic [1:0]    res_status;
  logic          res_found;
  logic [31:0]   res_value;
  logic          hash_start;
  logic          hash_done;
  logic [63:0]   hash;
  logic          hit;
  logic          act_pop;
  logic          act_put;
  logic          chain_hit;

  chte_hash u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .key   (op_key),
    .done  (hash_done),
    .hash  (hash)
  );

  assign hit = (rd_key == op_key);
  assign hash_start = (state == chte_pkg::ST_HASH);
  assign sweep_last = (sweep == SW'(SWEEP_N - 1));
  assign chain_hit = (state == chte_pkg::ST_ACT) && (cur < NULL_LINK) &&
                     (steps != (LW+1)'(POOL_NODES)) && hit;

  always_comb begin
    state_next = state;
    unique case (state)
      chte_pkg::ST_INIT:
        if (sweep_last) state_next = chte_pkg::ST_WAIT;
      chte_pkg::ST_WAIT: begin
        if (start) begin
          if (func == chte_pkg::FUNC_CLEAR) state_next = chte_pkg::ST_CLR;
          else if (func > chte_pkg::FUNC_CLEAR) state_next = chte_pkg::ST_RESP;
          else state_next = chte_pkg::ST_HASH;
        end
      end
      chte_pkg::ST_HASH:
        if (hash_done) state_next = chte_pkg::ST_HEAD;
      chte_pkg::ST_HEAD:
        state_next = chte_pkg::ST_READ;
      chte_pkg::ST_READ:
        if (cur >= NULL_LINK || steps == (LW+1)'(POOL_NODES)) state_next = chte_pkg::ST_ACT;
        else state_next = chte_pkg::ST_CMP;
      chte_pkg::ST_CMP:
        if (hit) state_next = chte_pkg::ST_ACT;
        else state_next = chte_pkg::ST_READ;
      chte_pkg::ST_ACT:
        if (op == chte_pkg::FUNC_PUT && !chain_hit && free_top != '0)
          state_next = chte_pkg::ST_FREE;
        else state_next = chte_pkg::ST_RESP;
      chte_pkg::ST_FREE:
        state_next = chte_pkg::ST_WR;
      chte_pkg::ST_WR:
        state_next = chte_pkg::ST_RESP;
      chte_pkg::ST_CLR:
        if (sweep_last) state_next = chte_pkg::ST_RESP;
      chte_pkg::ST_RESP:
        state_next = chte_pkg::ST_WAIT;
      default:
        state_next = chte_pkg::ST_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= chte_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep        <= '0;
      free_top     <= NULL_LINK;
      stored_count <= '0;
      strobe       <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        chte_pkg::ST_INIT: begin
          sweep <= sweep + SW'(1);
        end
        chte_pkg::ST_WAIT: begin
          if (start) begin
            op         <= func;
            op_key     <= key;
            op_value   <= value;
            res_status <= chte_pkg::ST_OK;
            res_found  <= 1'b0;
            res_value  <= 32'd0;
            if (func == chte_pkg::FUNC_CLEAR) begin
              sweep        <= '0;
              free_top     <= NULL_LINK;
              stored_count <= '0;
            end
          end
        end
        chte_pkg::ST_HASH: begin
          if (hash_done) bucket <= BW'(hash % 64'(NUM_BUCKETS));
        end
        chte_pkg::ST_HEAD: begin
          cur   <= bucket_head[bucket];
          prev  <= NULL_LINK;
          steps <= '0;
        end
        chte_pkg::ST_CMP: begin
          if (!hit) begin
            prev  <= cur;
            cur   <= rd_next;
            steps <= steps + (LW+1)'(1);
          end
        end
        chte_pkg::ST_ACT: begin
          unique case (op)
            chte_pkg::FUNC_PUT: begin
              if (chain_hit) begin
                res_found <= 1'b1;
              end else if (free_top == '0) begin
                res_status <= chte_pkg::ST_FULL;
              end else begin
                free_top <= free_top - LW'(1);
              end
            end
            chte_pkg::FUNC_GET, chte_pkg::FUNC_POP: begin
              if (chain_hit) begin
                res_found <= 1'b1;
                res_value <= rd_value;
                if (op == chte_pkg::FUNC_POP) begin
                  if (free_top < NULL_LINK) free_top <= free_top + LW'(1);
                  if (stored_count > '0) stored_count <= stored_count - LW'(1);
                end
              end else begin
                res_status <= chte_pkg::ST_NOT_FOUND;
              end
            end
            default: begin
              if (chain_hit) res_found <= 1'b1;
              else res_status <= chte_pkg::ST_NOT_FOUND;
            end
          endcase
        end
        chte_pkg::ST_FREE: begin
          cur <= LW'(rd_free);
        end
        chte_pkg::ST_WR: begin
          stored_count <= stored_count + LW'(1);
        end
        chte_pkg::ST_CLR: begin
          sweep <= sweep + SW'(1);
        end
        chte_pkg::ST_RESP: begin
          strobe <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign act_put = (state == chte_pkg::ST_WR);
  assign act_pop = chain_hit && (op == chte_pkg::FUNC_POP);

  // bucket heads
  always_ff @(posedge clk) begin
    if (state == chte_pkg::ST_INIT || state == chte_pkg::ST_CLR) begin
      if (sweep < SW'(NUM_BUCKETS)) bucket_head[BW'(sweep)] <= NULL_LINK;
    end else if (act_put) begin
      bucket_head[bucket] <= cur;
    end else if (act_pop && prev == NULL_LINK) begin
      bucket_head[bucket] <= rd_next;
    end
  end

  // node memories, one read address per cycle
  logic [NW-1:0] node_addr;
  assign node_addr = (act_pop && prev != NULL_LINK) ? NW'(prev) : NW'(cur);

  always_ff @(posedge clk) begin
    if (act_put) begin
      node_key[NW'(cur)]   <= op_key;
      node_value[NW'(cur)] <= op_value;
      node_next[NW'(cur)]  <= bucket_head[bucket];
    end else if (chain_hit && op == chte_pkg::FUNC_PUT) begin
      node_value[NW'(cur)] <= op_value;
    end else if (act_pop && prev != NULL_LINK) begin
      node_next[node_addr] <= rd_next;
    end
    rd_key   <= node_key[NW'(cur)];
    rd_value <= node_value[NW'(cur)];
    rd_next  <= node_next[NW'(cur)];
  end

  // free stack, read one below the top so a put finds its node ready
  always_ff @(posedge clk) begin
    if (state == chte_pkg::ST_INIT || state == chte_pkg::ST_CLR) begin
      if (sweep < SW'(POOL_NODES))
        free_stack[NW'(sweep)] <= NW'(SW'(POOL_NODES - 1) - sweep);
    end else if (act_pop && free_top < NULL_LINK) begin
      free_stack[NW'(free_top)] <= NW'(cur);
    end
    rd_free <= free_stack[NW'(free_top - LW'(1))];
  end

  assign busy        = (state != chte_pkg::ST_WAIT);
  assign status      = res_status;
  assign found       = res_found;
  assign value_out   = res_value;
  assign entry_count = 7'(stored_count);

  a_strobe_one: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe) else $error("strobe held two cycles");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    stored_count <= LW'(POOL_NODES)) else $error("entry count overflow");
  a_pool_balance: assert property (@(posedge clk) disable iff (rst)
    (state == chte_pkg::ST_WAIT) |-> (free_top + stored_count == NULL_LINK))
    else $error("free stack and count disagree");
  a_busy_strobe: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted word did not raise busy");

endmodule

// ===== tb/chte_checker.sv =====
`timescale 1ns / 100ps
// checker: watches request and result words, predicts the hash table and compares
module chte_checker #(
  parameter int NUM_BUCKETS = 16,
  parameter int POOL_NODES  = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  func,
  input  logic [31:0] key,
  input  logic [31:0] value,
  input  logic        strobe,
  input  logic [1:0]  status,
  input  logic        found,
  input  logic [31:0] value_out,
  input  logic [6:0]  entry_count,
  output int          fail_count,
  output int          pending,
  output int          result_count,
  output int          full_count
);

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [31:0] value_out;
    logic [6:0]  entry_count;
  } reply_t;

  localparam int NIL = POOL_NODES;

  int bucket_head [NUM_BUCKETS];
  logic [31:0] node_key [POOL_NODES];
  logic [31:0] node_val [POOL_NODES];
  int node_next [POOL_NODES];
  int free_list [POOL_NODES];
  int free_top;
  int stored;
  reply_t expected_replies [$];

  function automatic int bucket_of(logic [31:0] k);
    logic [63:0] x;
    x = {32'd0, k};
    x = x ^ (x >> 33);
    x = x * chte_pkg::MIX_C1;
    x = x ^ (x >> 33);
    x = x * chte_pkg::MIX_C2;
    x = x ^ (x >> 33);
    return int'(x % NUM_BUCKETS);
  endfunction

  task automatic clear_table();
    for (int i = 0; i < NUM_BUCKETS; i++) bucket_head[i] = NIL;
    for (int i = 0; i < POOL_NODES; i++) begin
      node_key[i] = '0;
      node_val[i] = '0;
      node_next[i] = NIL;
      free_list[i] = POOL_NODES - 1 - i;
    end
    free_top = POOL_NODES;
    stored = 0;
  endtask

  task automatic apply_word(logic [2:0] f, logic [31:0] k, logic [31:0] v);
    int b, cur, prev, hit, n;
    reply_t r;
    b = bucket_of(k);
    cur = bucket_head[b];
    prev = NIL;
    hit = NIL;
    r = '0;
    if (f <= chte_pkg::FUNC_CONTAINS) begin
      for (int s = 0; s < POOL_NODES && cur < POOL_NODES; s++) begin
        if (node_key[cur] == k) begin
          hit = cur;
          break;
        end
        prev = cur;
        cur = node_next[cur];
      end
    end
    case (f)
      chte_pkg::FUNC_PUT: begin
        if (hit != NIL) begin
          r.found = 1'b1;
          node_val[hit] = v;
        end else if (free_top == 0) begin
          r.status = chte_pkg::ST_FULL;
          full_count++;
        end else begin
          free_top--;
          n = free_list[free_top];
          node_key[n] = k;
          node_val[n] = v;
          node_next[n] = bucket_head[b];
          bucket_head[b] = n;
          stored++;
        end
      end
      chte_pkg::FUNC_GET, chte_pkg::FUNC_POP, chte_pkg::FUNC_CONTAINS: begin
        if (hit != NIL) begin
          r.found = 1'b1;
          if (f != chte_pkg::FUNC_CONTAINS) r.value_out = node_val[hit];
          if (f == chte_pkg::FUNC_POP) begin
            if (prev != NIL) node_next[prev] = node_next[hit];
            else bucket_head[b] = node_next[hit];
            if (free_top < POOL_NODES) begin
              free_list[free_top] = hit;
              free_top++;
            end
            if (stored > 0) stored--;
          end
        end else begin
          r.status = chte_pkg::ST_NOT_FOUND;
        end
      end
      chte_pkg::FUNC_CLEAR: clear_table();
      default: ;
    endcase
    r.entry_count = 7'(stored);
    expected_replies.push_back(r);
  endtask

  always @(posedge clk) begin
    reply_t got, exp_r;
    if (rst) begin
      clear_table();
      expected_replies.delete();
    end else begin
      if (strobe) begin
        got = {status, found, value_out, entry_count};
        result_count++;
        if (expected_replies.size() == 0) begin
          fail_count++;
          $display("%0t: result word with none expected: %p", $time, got);
        end else begin
          exp_r = expected_replies.pop_front();
          if (got.status !== exp_r.status) begin
            fail_count++;
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status, got.status);
          end
          if (got.found !== exp_r.found) begin
            fail_count++;
            $display("%0t: found expected %0d actual %0d", $time, exp_r.found, got.found);
          end
          if (got.value_out !== exp_r.value_out) begin
            fail_count++;
            $display("%0t: value_out expected %h actual %h", $time, exp_r.value_out,
                     got.value_out);
          end
          if (got.entry_count !== exp_r.entry_count) begin
            fail_count++;
            $display("%0t: entry_count expected %0d actual %0d", $time, exp_r.entry_count,
                     got.entry_count);
          end
        end
      end
      if (start && !busy) apply_word(func, key, value);
    end
    pending = expected_replies.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
    result_count = 0;
    full_count = 0;
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// testbench top: drives request words into the hash table engine and reports the verdict
module tb;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  func = '0;
  logic [31:0] key = '0;
  logic [31:0] value = '0;
  logic        strobe;
  logic [1:0]  status;
  logic        found;
  logic [31:0] value_out;
  logic [6:0]  entry_count;
  int          fail_count, pending, result_count, full_count;
  int          idle_pct;
  int          sent;
  logic [31:0] key_pool [16];

  always #1 clk = ~clk;

  chained_hash_table_engine dut (.*);

  chte_checker chk (.*);

  task automatic send_word(logic [2:0] f, logic [31:0] k, logic [31:0] v);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      func  <= 3'($urandom);
      key   <= $urandom;
      value <= $urandom;
      @(negedge clk);
    end
    start <= 1'b1;
    func  <= f;
    key   <= k;
    value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  function automatic logic [31:0] pick_key();
    return ($urandom_range(3) == 0) ? $urandom : key_pool[$urandom_range(15)];
  endfunction

  task automatic random_words(int n);
    int r;
    logic [2:0] f;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 40) f = chte_pkg::FUNC_PUT;
      else if (r < 58) f = chte_pkg::FUNC_GET;
      else if (r < 78) f = chte_pkg::FUNC_POP;
      else if (r < 93) f = chte_pkg::FUNC_CONTAINS;
      else if (r < 95) f = chte_pkg::FUNC_CLEAR;
      else f = 3'($urandom_range(7, 5));
      send_word(f, pick_key(), $urandom);
    end
  endtask

  initial begin
    sent = 0;
    idle_pct = 29;
    for (int i = 0; i < 16; i++) key_pool[i] = $urandom;
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hffffffff;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    send_word(chte_pkg::FUNC_GET, 32'h0, 32'hffffffff);
    send_word(chte_pkg::FUNC_PUT, 32'h0, 32'hffffffff);
    send_word(chte_pkg::FUNC_PUT, 32'hffffffff, 32'h0);
    send_word(chte_pkg::FUNC_PUT, 32'h0, 32'h12345678);
    send_word(chte_pkg::FUNC_GET, 32'h0, 32'h0);
    send_word(chte_pkg::FUNC_CONTAINS, 32'hffffffff, 32'h0);
    send_word(chte_pkg::FUNC_CONTAINS, 32'h5a5a5a5a, 32'h0);
    send_word(chte_pkg::FUNC_POP, 32'h0, 32'h0);
    send_word(chte_pkg::FUNC_POP, 32'h0, 32'h0);
    send_word(3'd5, 32'h1, 32'h1);
    send_word(3'd6, 32'h2, 32'h2);
    send_word(3'd7, 32'h3, 32'h3);
    send_word(chte_pkg::FUNC_CLEAR, 32'hffffffff, 32'hffffffff);
    // fill the pool, overflow it, then drain part of it
    for (int i = 0; i < 66; i++) send_word(chte_pkg::FUNC_PUT, 32'(i * 7 + 1), $urandom);
    for (int i = 0; i < 20; i++) send_word(chte_pkg::FUNC_POP, 32'(i * 21 + 1), 32'h0);
    for (int i = 0; i < 4; i++) send_word(chte_pkg::FUNC_PUT, $urandom, $urandom);
    send_word(chte_pkg::FUNC_CLEAR, 32'h0, 32'h0);

    random_words(120);
    idle_pct = 58;
    random_words(120);
    idle_pct = 0;
    random_words(120);
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("sent %0d words, checked %0d results, %0d pool-full puts", sent, result_count,
             full_count);
    $display("covered every operation, unknown codes, duplicate puts, absent keys and clears");
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #400000;
    $display("Some tests failed");
    $finish;
  end

endmodule
